[rtl/conv3x3_kernel_bank_filter_top_assert.svh]
// Assertion macros for the 3x3 kernel bank filter top level.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef CONV3X3_KERNEL_BANK_FILTER_TOP_ASSERT_SVH
`define CONV3X3_KERNEL_BANK_FILTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C3KBF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define C3KBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/c3kbf_pkg.sv]
// Shared types and constants of the 3x3 kernel bank filter.
// Used by every module of the block except the generic RAM.
package c3kbf_pkg;

	localparam int PIXEL_W     = 8;
	localparam int VALUE_W     = 13;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int FSIZE_W     = 9;
	localparam int KSEL_W      = 3;
	localparam int TAPS        = 9;
	localparam int TAP_IDX_W   = 4;

	// Division by 9 of a sum in 0..4080 as a multiply by ceil(2^16 / 9) and a shift.
	localparam int              MAG_W        = 12;
	localparam int              RECIP9_W     = 13;
	localparam int              QUO_W        = MAG_W + RECIP9_W;
	localparam int              RECIP9_SHIFT = 16;
	localparam logic [RECIP9_W-1:0] RECIP9   = 13'd7282;

	// Output queue; the depth must be a power of two.
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
	localparam int OUT_W     = VALUE_W + 1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_KERNEL_SELECT = 2'd0,
		REG_SCALED_MODE   = 2'd1,
		REG_FRAME_SIZE    = 2'd2
	} c3kbf_reg_t;

	localparam logic [KSEL_W-1:0]  KSEL_RESET  = 3'd1;
	localparam logic [FSIZE_W-1:0] FSIZE_RESET = 9'd256;

	typedef logic signed [4:0] c3kbf_coef_t;

	// Per-position control that travels with an item through the pipeline.
	typedef struct packed {
		logic emit;
		logic last;
		logic mask_top;
		logic mask_left;
		logic mask_right;
	} c3kbf_meta_t;

	// Kernel weights, row by row; code 7 is the all-zero kernel.
	localparam c3kbf_coef_t KERNEL_TAB [0:7][0:8] = '{
		'{-5'sd1, 5'sd0, 5'sd1, -5'sd1, 5'sd0, 5'sd1, -5'sd1, 5'sd0, 5'sd1},
		'{5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1},
		'{5'sd1, 5'sd2, 5'sd1, 5'sd0, 5'sd0, 5'sd0, -5'sd1, -5'sd2, -5'sd1},
		'{-5'sd1, 5'sd0, 5'sd1, -5'sd2, 5'sd0, 5'sd2, -5'sd1, 5'sd0, 5'sd1},
		'{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
		'{-5'sd1, -5'sd1, 5'sd0, -5'sd1, 5'sd0, 5'sd1, 5'sd0, 5'sd1, 5'sd1},
		'{5'sd1, 5'sd2, 5'sd1, 5'sd2, 5'sd4, 5'sd2, 5'sd1, 5'sd2, 5'sd1},
		'{5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0}
	};

	function automatic c3kbf_coef_t kernel_weight(input logic [KSEL_W-1:0] ksel,
			input logic [TAP_IDX_W-1:0] idx);
		return KERNEL_TAB[ksel][idx];
	endfunction

endpackage

[rtl/c3kbf_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address being written returns the old contents. No dependencies.
module c3kbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/c3kbf_scan.sv]
// Raster position tracking: column, row and output counters, frame restart,
// drain handling and border masks. Depends on c3kbf_pkg.
module c3kbf_scan import c3kbf_pkg::*; #(
	parameter int MAX_WIDTH = 256,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               op,
	input  logic [PIXEL_W-1:0] pixel,
	input  logic [FSIZE_W-1:0] frame_size,
	output logic               item_valid,
	output logic [AW-1:0]      item_addr,
	output logic [PIXEL_W-1:0] item_x,
	output c3kbf_meta_t        item_meta
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_WIDTH + 3);
	localparam int XW = (CW > FSIZE_W) ? CW : FSIZE_W;
	localparam int EW = 2 * CW;

	logic [XW-1:0] fs_x, mw_x, n_x;
	logic [CW-1:0] n, col_q, c0, c_inc;
	logic [RW-1:0] row_q, r0, n_r;
	logic [EW-1:0] em_q, nn_q, em_base, em_inc;
	logic          restart, drop, emit, last;

	always_comb begin
		fs_x = XW'(frame_size);
		mw_x = XW'(MAX_WIDTH);
		if (fs_x < XW'(2)) begin
			n_x = XW'(2);
		end else if (fs_x > mw_x) begin
			n_x = mw_x;
		end else begin
			n_x = fs_x;
		end
		n   = CW'(n_x);
		n_r = RW'(n);

		// A column count at or past the frame width wraps to the next row.
		c0 = col_q;
		r0 = row_q;
		if (col_q >= n) begin
			c0 = '0;
			r0 = row_q + RW'(1);
		end
		restart = (r0 >= n_r + RW'(2));
		if (restart) begin
			c0 = '0;
			r0 = '0;
		end
		em_base = restart ? '0 : em_q;

		drop  = op && (c0 == '0) && (r0 == '0);
		emit  = (r0 >= RW'(2)) || ((r0 == RW'(1)) && (c0 >= CW'(1)));
		em_inc = em_base + EW'(1);
		last  = emit && (em_inc >= nn_q);
		c_inc = c0 + CW'(1);
	end

	always_comb begin
		item_valid          = accept && !drop;
		item_addr           = c0[AW-1:0];
		item_x              = (!op && (r0 < n_r)) ? pixel : '0;
		item_meta.emit      = emit;
		item_meta.last      = last;
		if (c0 != '0) begin
			item_meta.mask_top   = (r0 == RW'(1));
			item_meta.mask_left  = (c0 == CW'(1));
			item_meta.mask_right = 1'b0;
		end else begin
			item_meta.mask_top   = (r0 == RW'(2));
			item_meta.mask_left  = 1'b0;
			item_meta.mask_right = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			em_q  <= '0;
			nn_q  <= '0;
		end else begin
			nn_q <= EW'(n) * EW'(n);
			if (accept) begin
				if (drop) begin
					col_q <= c0;
					row_q <= r0;
					em_q  <= em_base;
				end else if (last) begin
					col_q <= '0;
					row_q <= '0;
					em_q  <= '0;
				end else begin
					if (c_inc >= n) begin
						col_q <= '0;
						row_q <= r0 + RW'(1);
					end else begin
						col_q <= c_inc;
						row_q <= r0;
					end
					em_q <= emit ? em_inc : em_base;
				end
			end
		end
	end

endmodule

[rtl/c3kbf_window.sv]
// Line stores in two RAMs with read-modify-write, forwarding and the 3x3 window.
// Clears both RAMs after reset. Depends on c3kbf_pkg and c3kbf_ram.
module c3kbf_window import c3kbf_pkg::*; #(
	parameter int MAX_WIDTH = 256,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [AW-1:0]             in_addr,
	input  logic [PIXEL_W-1:0]        in_x,
	input  c3kbf_meta_t               in_meta,
	output logic                      out_valid,
	output c3kbf_meta_t               out_meta,
	output logic [8:0][PIXEL_W-1:0]   window,
	output logic                      clr_busy
);

	logic               v_s1, fwd_s1;
	logic [AW-1:0]      addr_s1;
	logic [PIXEL_W-1:0] x_s1, fwd_up_s1, fwd_mid_s1;
	c3kbf_meta_t        meta_s1;
	logic [PIXEL_W-1:0] rd_up, rd_mid, up, mid;
	logic               clr_q;
	logic [AW-1:0]      clr_addr_q;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [PIXEL_W-1:0] wd_up, wd_mid;
	logic [8:0][PIXEL_W-1:0] win_q;
	logic               v_s2;
	c3kbf_meta_t        meta_s2;

	// The RAM returns old data when the entry is written in the same cycle,
	// so the item just ahead hands over what it writes.
	assign up  = fwd_s1 ? fwd_up_s1 : rd_up;
	assign mid = fwd_s1 ? fwd_mid_s1 : rd_mid;

	assign we     = clr_q || v_s1;
	assign waddr  = clr_q ? clr_addr_q : addr_s1;
	assign wd_up  = clr_q ? '0 : mid;
	assign wd_mid = clr_q ? '0 : x_s1;

	c3kbf_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wd_up),
		.re    (in_valid),
		.raddr (in_addr),
		.rdata (rd_up)
	);

	c3kbf_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wd_mid),
		.re    (in_valid),
		.raddr (in_addr),
		.rdata (rd_mid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
			v_s2   <= 1'b0;
			win_q  <= '0;
		end else begin
			v_s1   <= in_valid;
			fwd_s1 <= in_valid && v_s1 && (in_addr == addr_s1);
			v_s2   <= v_s1 && meta_s1.emit;
			if (v_s1) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= up;
				win_q[3] <= win_q[4];
				win_q[4] <= win_q[5];
				win_q[5] <= mid;
				win_q[6] <= win_q[7];
				win_q[7] <= win_q[8];
				win_q[8] <= x_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= in_addr;
		x_s1       <= in_x;
		meta_s1    <= in_meta;
		fwd_up_s1  <= mid;
		fwd_mid_s1 <= x_s1;
		meta_s2    <= meta_s1;
	end

	assign out_valid = v_s2;
	assign out_meta  = meta_s2;
	assign window    = win_q;
	assign clr_busy  = clr_q;

endmodule

[rtl/c3kbf_arith.sv]
// Kernel arithmetic: masked weighted taps, sum, and the optional divide by 9
// with clamp, over three register stages. Depends on c3kbf_pkg.
module c3kbf_arith import c3kbf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  c3kbf_meta_t              in_meta,
	input  logic [8:0][PIXEL_W-1:0]  window,
	input  logic [KSEL_W-1:0]        kernel_select,
	input  logic                     scaled_mode,
	output logic                     out_valid,
	output logic signed [VALUE_W-1:0] out_value,
	output logic                     out_last
);

	logic signed [VALUE_W-1:0] prod [TAPS];
	logic signed [VALUE_W-1:0] prod_s3 [TAPS];
	logic                      v_s3, last_s3;
	logic signed [VALUE_W:0]   acc;
	logic signed [VALUE_W-1:0] sum_s4;
	logic                      v_s4, last_s4;
	logic [QUO_W-1:0]          quo_s5;
	logic signed [VALUE_W-1:0] raw_s5;
	logic                      v_s5, last_s5, neg_s5, scaled_s5;

	for (genvar i = 0; i < TAPS; i++) begin : g_tap
		localparam int R = i / 3;
		localparam int C = i % 3;
		logic                      kill;
		logic [PIXEL_W-1:0]        tap;
		logic signed [VALUE_W-1:0] coef;
		assign kill = ((R == 0) && in_meta.mask_top) || ((C == 0) && in_meta.mask_left)
			|| ((C == 2) && in_meta.mask_right);
		assign tap  = kill ? '0 : window[i];
		assign coef = VALUE_W'(kernel_weight(kernel_select, TAP_IDX_W'(i)));
		assign prod[i] = $signed({{(VALUE_W - PIXEL_W){1'b0}}, tap}) * coef;
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < TAPS; i++) begin
			acc = acc + (VALUE_W + 1)'(prod_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3   <= prod;
		last_s3   <= in_meta.last;
		sum_s4    <= VALUE_W'(acc);
		last_s4   <= last_s3;
		quo_s5    <= QUO_W'(sum_s4[MAG_W-1:0]) * QUO_W'(RECIP9);
		raw_s5    <= sum_s4;
		neg_s5    <= sum_s4[VALUE_W-1];
		scaled_s5 <= scaled_mode;
		last_s5   <= last_s4;
	end

	// Any negative sum divided by 9 truncates to zero or below and clamps to zero.
	always_comb begin
		if (!scaled_s5) begin
			out_value = raw_s5;
		end else if (neg_s5) begin
			out_value = '0;
		end else begin
			out_value = VALUE_W'(quo_s5[QUO_W-1:RECIP9_SHIFT]);
		end
	end

	assign out_valid = v_s5;
	assign out_last  = last_s5;

endmodule

[rtl/c3kbf_out_fifo.sv]
// Small output queue that decouples the arithmetic pipeline from the receiver.
// Depends on c3kbf_pkg for its depth and entry width.
module c3kbf_out_fifo import c3kbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [OUT_W-1:0] din,
	input  logic             pop,
	output logic             valid,
	output logic [OUT_W-1:0] dout
);

	logic [OUT_W-1:0]     mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_q, rd_q;
	logic [OUT_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + OUT_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OUT_CNT_W'(1);
			end else if (!push && pop) begin
				cnt_q <= cnt_q - OUT_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_q];

endmodule

[rtl/conv3x3_kernel_bank_filter_top.sv]
// 3x3 kernel bank image filter, top level.
// Input stream: one transfer per pixel of a square frame in raster order; tuser
// carries op (0 pixel, 1 drain step), tdata the pixel. After the frame, frame_size+1
// drain transfers flush the remaining results. Output stream: one transfer per
// output position, tdata bits 12:0 hold the two's complement value, tlast marks
// the final position of the frame.
// Throughput is one input transfer per clock while s_axis_tready is high. A result
// passes from the input transfer that completes its window through the registered
// line store read, then the window, the tap products, the sum and the divide by 9,
// which each take one register stage, and then the output queue; the two line
// stores are single read, single write RAMs with a registered read port.
// After reset both line stores are cleared, one entry per cycle, so s_axis_tready
// stays low until the clearing is done. A configuration write holds tready low for
// the following cycle. When the receiver stalls, results collect in an
// eight-entry queue and tready drops once results in flight would fill it.
// Depends on c3kbf_pkg, c3kbf_scan, c3kbf_window, c3kbf_arith, c3kbf_out_fifo.
module conv3x3_kernel_bank_filter_top import c3kbf_pkg::*; #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel
	input  logic [0:0]             s_axis_tuser,   // [0] op
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [12:0] value, [15:13] zero
	output logic                   m_axis_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic [KSEL_W-1:0]  ksel_q;
	logic               scaled_q;
	logic [FSIZE_W-1:0] fsize_q;
	logic               cfg_gap_q;
	logic [OUT_CNT_W-1:0] pending_q;

	logic               in_accept, out_accept;
	logic               item_valid;
	logic [AW-1:0]      item_addr;
	logic [PIXEL_W-1:0] item_x;
	c3kbf_meta_t        item_meta;
	logic               win_valid;
	c3kbf_meta_t        win_meta;
	logic [8:0][PIXEL_W-1:0] window;
	logic               clr_busy;
	logic               res_valid, res_last;
	logic signed [VALUE_W-1:0] res_value;
	logic [OUT_W-1:0]   q_dout;
	logic               credit_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksel_q    <= KSEL_RESET;
			scaled_q  <= 1'b1;
			fsize_q   <= FSIZE_RESET;
			cfg_gap_q <= 1'b0;
		end else begin
			cfg_gap_q <= cfg_we;
			if (cfg_we) begin
				case (c3kbf_reg_t'(cfg_addr))
					REG_KERNEL_SELECT: ksel_q   <= cfg_wdata[KSEL_W-1:0];
					REG_SCALED_MODE:   scaled_q <= cfg_wdata[0];
					REG_FRAME_SIZE:    fsize_q  <= cfg_wdata[FSIZE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Every accepted item that will produce a result reserves a queue slot.
	assign s_axis_tready = !clr_busy && !cfg_gap_q && (pending_q < OUT_CNT_W'(OUT_DEPTH));
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_accept    = m_axis_tvalid && m_axis_tready;
	assign credit_take   = item_valid && item_meta.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (credit_take && !out_accept) begin
			pending_q <= pending_q + OUT_CNT_W'(1);
		end else if (!credit_take && out_accept) begin
			pending_q <= pending_q - OUT_CNT_W'(1);
		end
	end

	c3kbf_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.op         (s_axis_tuser[0]),
		.pixel      (s_axis_tdata),
		.frame_size (fsize_q),
		.item_valid (item_valid),
		.item_addr  (item_addr),
		.item_x     (item_x),
		.item_meta  (item_meta)
	);

	c3kbf_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_addr   (item_addr),
		.in_x      (item_x),
		.in_meta   (item_meta),
		.out_valid (win_valid),
		.out_meta  (win_meta),
		.window    (window),
		.clr_busy  (clr_busy)
	);

	c3kbf_arith u_arith (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (win_valid),
		.in_meta       (win_meta),
		.window        (window),
		.kernel_select (ksel_q),
		.scaled_mode   (scaled_q),
		.out_valid     (res_valid),
		.out_value     (res_value),
		.out_last      (res_last)
	);

	c3kbf_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    ({res_last, res_value}),
		.pop    (out_accept),
		.valid  (m_axis_tvalid),
		.dout   (q_dout)
	);

	assign m_axis_tdata = OUT_TDATA_W'(q_dout[VALUE_W-1:0]);
	assign m_axis_tlast = q_dout[VALUE_W];

	`include "conv3x3_kernel_bank_filter_top_assert.svh"

	`C3KBF_ASSERT_SAME(a_clear_blocks_input, clr_busy, !s_axis_tready, "input taken during line store clearing")
	`C3KBF_ASSERT_SAME(a_output_has_credit, m_axis_tvalid, pending_q != '0, "result shown without a reserved slot")
	`C3KBF_ASSERT_SAME(a_credit_bounded, 1'b1, pending_q <= OUT_CNT_W'(OUT_DEPTH), "reserved slots exceed queue depth")
	`C3KBF_ASSERT_NEXT(a_cfg_gap, cfg_we, !s_axis_tready, "input taken right after a register write")

endmodule
